/* rtl/core/poisson_pkg.sv */
// Package for the Poisson sampler: sequencer states, fixed-point constants,
// shift codes of the shared multiplier and the divisor table of the trig series.
// No dependencies.
package poisson_pkg;

  localparam int          SMALL_MEAN_BORDER_DEF   = 16;
  localparam int          MAX_INVERSION_STEPS_DEF = 64;
  localparam int          FRACTION_BITS_DEF       = 32;

  localparam logic [30:0] SAT_LIMIT  = 31'd2000000000;
  localparam logic [63:0] LN2_Q48    = 64'h0000_B172_17F7_D1CF;
  localparam logic [63:0] LN2_Q64    = 64'hB172_17F7_D1CF_79AC;
  localparam logic [63:0] HALFPI_Q62 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] ONE_Q60    = 64'h1000_0000_0000_0000;
  localparam logic [63:0] SQRT_TOP   = 64'h4000_0000_0000_0000;
  localparam logic [65:0] HALF_Q16   = 66'h8000;

  localparam logic [6:0]  SH_Q16 = 7'd16;
  localparam logic [6:0]  SH_Q33 = 7'd33;
  localparam logic [6:0]  SH_Q36 = 7'd36;
  localparam logic [6:0]  SH_Q60 = 7'd60;
  localparam logic [6:0]  SH_Q62 = 7'd62;
  localparam logic [6:0]  SH_Q63 = 7'd63;

  localparam int          EXP_TERMS  = 20;
  localparam int          TRIG_TERMS = 14;

  typedef enum logic [4:0] {
    ST_IDLE, ST_E_DIV, ST_E_DIVD, ST_E_MUL, ST_E_MULD, ST_E_TERM, ST_E_FIN,
    ST_I_CHK, ST_I_MULD, ST_I_ADD,
    ST_L_NORM, ST_L_SQ, ST_L_SQD, ST_L_LQ, ST_L_SR,
    ST_C_A, ST_C_A2, ST_C_INIT, ST_C_MUL, ST_C_DIV, ST_C_TERM, ST_C_FIN,
    ST_N_SM, ST_N_D, ST_N_VAL, ST_OUT,
    ST_MUL, ST_MSH, ST_DIV, ST_SQB, ST_SQS
  } poisson_state_e;

  // sine series divides by 2n(2n+1), cosine series by (2n-1)2n
  function automatic logic [9:0] trig_div(input logic [3:0] n, input logic odd);
    logic [4:0] lo;
    logic [4:0] hi;
    begin
      lo = odd ? {n, 1'b0} : {n, 1'b0} - 5'd1;
      hi = lo + 5'd1;
      trig_div = 10'(lo * hi);
    end
  endfunction

endpackage

/* rtl/core/poisson_sampler_unit.sv */
// Poisson sampler top level: sequencer around one shared 32x32 multiplier,
// a radix-2 divider and a bit-pair square-root unit.
// Depends on poisson_pkg.
//
// Use: one request enters on in_valid_i/in_stall_o with a Q16.16 mean and two
// uniform codes; one result leaves on out_valid_o/out_stall_i with the count
// and a flag for an iteration cap or saturation.
// The sequencer works on one request at a time and holds in_stall_o high from
// acceptance until its result has moved into the output register.
// A 64-bit multiply takes four partial products and one shift, a divide
// yields one quotient bit a cycle, and a square root works on bit pairs.
// Means up to the border spend their time on exp(-mean) and the inversion
// steps; larger means spend most of it in the 14 divides of the sine or
// cosine series. The result then moves into the output register. The
// divider sets the throughput.
// Reset returns the sequencer to idle, empties the output register and drops
// any request in flight.
// While the receiver stalls the result is held in the output register; one
// further request is taken and computed, then the sequencer waits.
module poisson_sampler_unit import poisson_pkg::*; #(
  parameter int SMALL_MEAN_BORDER   = SMALL_MEAN_BORDER_DEF,
  parameter int MAX_INVERSION_STEPS = MAX_INVERSION_STEPS_DEF,
  parameter int FRACTION_BITS       = FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] mean_fixed_i,
  input  logic [31:0] uniform_first_i,
  input  logic [31:0] uniform_second_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [30:0] sample_count_o,
  output logic        capped_flag_o
);

  localparam int          KW       = $clog2(MAX_INVERSION_STEPS + 1);
  localparam int          USH_L    = (FRACTION_BITS >= 33) ? FRACTION_BITS - 33 : 0;
  localparam int          USH_R    = (FRACTION_BITS >= 33) ? 0 : 33 - FRACTION_BITS;
  localparam logic [31:0] BORDER_Q = 32'(SMALL_MEAN_BORDER) << 16;
  localparam logic [64:0] EXP_SH   = 65'(60 - FRACTION_BITS);
  localparam logic [KW-1:0] K_MAX  = KW'(MAX_INVERSION_STEPS);
  localparam logic [KW-1:0] K_EXP  = KW'(EXP_TERMS);
  localparam logic [KW-1:0] K_TRIG = KW'(TRIG_TERMS);

  poisson_state_e state_q, state_d, ret_q, ret_d;

  logic [31:0]    mean_q, mean_d;
  logic [32:0]    v1_q, v1_d, v2_q, v2_d;
  logic [63:0]    y_q, y_d, sum_q, sum_d, opr_q, opr_d, a_q, a_d;
  logic [63:0]    n_q, n_d, s28_q, s28_d;
  logic [31:0]    frac_q, frac_d;
  logic [5:0]     b_q, b_d;
  logic [KW-1:0]  k_q, k_d;
  logic [30:0]    count_q, count_d;
  logic           flag_q, flag_d;
  logic [63:0]    ma_q, ma_d, mb_q, mb_d, mres_q, mres_d;
  logic [6:0]     msh_q, msh_d;
  logic [127:0]   prod_q, prod_d;
  logic [1:0]     midx_q, midx_d;
  logic [63:0]    dn_q, dn_d, dd_q, dd_d, dr_q, dr_d;
  logic [5:0]     dcnt_q, dcnt_d;
  logic [63:0]    sx_q, sx_d, sr_q, sr_d, sb_q, sb_d;
  logic           res_valid_q, res_valid_d;
  logic [30:0]    res_count_q, res_count_d;
  logic           res_flag_q, res_flag_d;

  logic [63:0]    u_val;
  logic [64:0]    rem_sh, rem_sub;
  logic           dge;
  logic [31:0]    ah, bh;
  logic [63:0]    pp;
  logic [127:0]   pp_sh;
  logic [63:0]    srb;
  logic [64:0]    esh;
  logic [63:0]    ep;
  logic           neg;
  logic [65:0]    vpos, vsum;
  logic [49:0]    vcnt;
  logic [63:0]    csum;
  logic [63:0]    lq;
  logic           load_res;

  assign u_val   = ({31'd0, v1_q} << USH_L) >> USH_R;
  assign rem_sh  = {dr_q, dn_q[63]};
  assign dge     = rem_sh >= {1'b0, dd_q};
  assign rem_sub = rem_sh - {1'b0, dd_q};
  assign ah      = midx_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign bh      = midx_q[0] ? mb_q[63:32] : mb_q[31:0];
  assign pp      = 64'(ah) * 64'(bh);
  assign pp_sh   = {64'd0, pp} << {(2'(midx_q[1]) + 2'(midx_q[0])), 5'd0};
  assign srb     = sr_q + sb_q;
  assign esh     = {1'b0, n_q} + EXP_SH;
  assign ep      = (esh >= 65'd64) ? 64'd0 : sum_q >> esh[5:0];
  assign neg     = v2_q[32] ^ v2_q[31];
  assign vpos    = {34'd0, mean_q} + HALF_Q16;
  assign vsum    = neg ? vpos - {2'b00, mres_q} : vpos + {2'b00, mres_q};
  assign vcnt    = vsum[65:16];
  assign csum    = sum_q[63] ? 64'd0 : sum_q;
  assign lq      = {26'd0, 6'd33 - b_q, 32'd0} - {32'd0, frac_q};

  assign load_res    = (state_q == ST_OUT) && (!res_valid_q || !out_stall_i);
  assign res_valid_d = load_res || (res_valid_q && out_stall_i);
  assign res_count_d = load_res ? count_q : res_count_q;
  assign res_flag_d  = load_res ? flag_q : res_flag_q;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) begin
                   state_d = (mean_fixed_i <= BORDER_Q) ? ST_E_DIV : ST_L_NORM;
                 end
      ST_E_DIV:  begin state_d = ST_DIV; ret_d = ST_E_DIVD; end
      ST_E_DIVD: state_d = ST_E_MUL;
      ST_E_MUL:  begin state_d = ST_MUL; ret_d = ST_E_MULD; end
      ST_E_MULD: begin state_d = ST_DIV; ret_d = ST_E_TERM; end
      ST_E_TERM: state_d = (k_q == K_EXP) ? ST_E_FIN : ST_E_MUL;
      ST_E_FIN:  state_d = ST_I_CHK;
      ST_I_CHK:  begin
                   if (sum_q > u_val || k_q >= K_MAX) begin
                     state_d = ST_OUT;
                   end else begin
                     state_d = ST_MUL;
                     ret_d   = ST_I_MULD;
                   end
                 end
      ST_I_MULD: begin state_d = ST_DIV; ret_d = ST_I_ADD; end
      ST_I_ADD:  state_d = ST_I_CHK;
      ST_L_NORM: if (y_q[62]) state_d = ST_L_SQ;
      ST_L_SQ:   begin state_d = ST_MUL; ret_d = ST_L_SQD; end
      ST_L_SQD:  state_d = (k_q[4:0] == 5'd31) ? ST_L_LQ : ST_L_SQ;
      ST_L_LQ:   begin state_d = ST_MUL; ret_d = ST_L_SR; end
      ST_L_SR:   begin state_d = ST_SQB; ret_d = ST_C_A; end
      ST_C_A:    begin state_d = ST_MUL; ret_d = ST_C_A2; end
      ST_C_A2:   begin state_d = ST_MUL; ret_d = ST_C_INIT; end
      ST_C_INIT: state_d = ST_C_MUL;
      ST_C_MUL:  begin state_d = ST_MUL; ret_d = ST_C_DIV; end
      ST_C_DIV:  begin state_d = ST_DIV; ret_d = ST_C_TERM; end
      ST_C_TERM: state_d = (k_q == K_TRIG) ? ST_C_FIN : ST_C_MUL;
      ST_C_FIN:  begin state_d = ST_MUL; ret_d = ST_N_SM; end
      ST_N_SM:   begin state_d = ST_SQB; ret_d = ST_N_D; end
      ST_N_D:    begin state_d = ST_MUL; ret_d = ST_N_VAL; end
      ST_N_VAL:  state_d = ST_OUT;
      ST_OUT:    if (!res_valid_q || !out_stall_i) state_d = ST_IDLE;
      ST_MUL:    if (midx_q == 2'd3) state_d = ST_MSH;
      ST_MSH:    state_d = ret_q;
      ST_DIV:    if (dcnt_q == 6'd63) state_d = ret_q;
      ST_SQB:    if (!(sb_q > sx_q)) state_d = ST_SQS;
      ST_SQS:    if (sb_q == 64'd0) state_d = ret_q;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    mean_d = mean_q; v1_d = v1_q; v2_d = v2_q;
    y_d = y_q; sum_d = sum_q; opr_d = opr_q; a_d = a_q; n_d = n_q; s28_d = s28_q;
    frac_d = frac_q; b_d = b_q; k_d = k_q; count_d = count_q; flag_d = flag_q;
    ma_d = ma_q; mb_d = mb_q; msh_d = msh_q; prod_d = prod_q; midx_d = midx_q;
    mres_d = mres_q;
    dn_d = dn_q; dd_d = dd_q; dr_d = dr_q; dcnt_d = dcnt_q;
    sx_d = sx_q; sr_d = sr_q; sb_d = sb_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) begin
        mean_d  = mean_fixed_i;
        v1_d    = {uniform_first_i, 1'b1};
        v2_d    = {uniform_second_i, 1'b1};
        y_d     = {1'b0, uniform_first_i, 1'b1, 30'd0};
        b_d     = 6'd32;
        frac_d  = '0;
        k_d     = '0;
        count_d = '0;
        flag_d  = 1'b0;
      end
      ST_E_DIV: begin
        dn_d = {mean_q, 32'd0}; dd_d = LN2_Q48; dr_d = '0; dcnt_d = '0;
      end
      ST_E_DIVD: begin
        n_d = dn_q; opr_d = dr_q << 12; y_d = ONE_Q60; sum_d = ONE_Q60; k_d = KW'(1);
      end
      ST_E_MUL: begin
        ma_d = y_q; mb_d = opr_q; msh_d = SH_Q60; prod_d = '0; midx_d = '0;
      end
      ST_E_MULD, ST_I_MULD: begin
        dn_d = mres_q; dd_d = 64'(k_q); dr_d = '0; dcnt_d = '0;
      end
      ST_E_TERM, ST_C_TERM: begin
        y_d   = dn_q;
        sum_d = k_q[0] ? sum_q - dn_q : sum_q + dn_q;
        k_d   = k_q + KW'(1);
      end
      ST_E_FIN: begin
        y_d = ep; sum_d = ep; k_d = '0;
      end
      ST_I_CHK: begin
        if (sum_q > u_val) begin
          count_d = 31'(k_q);
        end else if (k_q >= K_MAX) begin
          count_d = 31'(k_q);
          flag_d  = 1'b1;
        end else begin
          k_d  = k_q + KW'(1);
          ma_d = y_q; mb_d = {32'd0, mean_q}; msh_d = SH_Q16; prod_d = '0; midx_d = '0;
        end
      end
      ST_I_ADD: begin
        y_d = dn_q; sum_d = sum_q + dn_q;
      end
      ST_L_NORM: if (!y_q[62]) begin
        y_d = y_q << 1; b_d = b_q - 6'd1;
      end
      ST_L_SQ: begin
        ma_d = y_q; mb_d = y_q; msh_d = SH_Q62; prod_d = '0; midx_d = '0;
      end
      ST_L_SQD: begin
        if (mres_q[63]) begin
          y_d    = mres_q >> 1;
          frac_d = frac_q | (32'h8000_0000 >> k_q[4:0]);
        end else begin
          y_d = mres_q;
        end
        k_d = k_q + KW'(1);
      end
      ST_L_LQ: begin
        ma_d = lq; mb_d = LN2_Q64; msh_d = SH_Q63; prod_d = '0; midx_d = '0;
      end
      ST_L_SR: begin
        sx_d = mres_q << 24; sr_d = '0; sb_d = SQRT_TOP;
      end
      ST_C_A: begin
        s28_d = sr_q;
        ma_d = {33'd0, v2_q[30:0]}; mb_d = HALFPI_Q62; msh_d = SH_Q33;
        prod_d = '0; midx_d = '0;
      end
      ST_C_A2: begin
        a_d = mres_q;
        ma_d = mres_q; mb_d = mres_q; msh_d = SH_Q60; prod_d = '0; midx_d = '0;
      end
      ST_C_INIT: begin
        opr_d = mres_q;
        y_d   = v2_q[31] ? a_q : ONE_Q60;
        sum_d = v2_q[31] ? a_q : ONE_Q60;
        k_d   = KW'(1);
      end
      ST_C_MUL: begin
        ma_d = y_q; mb_d = opr_q; msh_d = SH_Q60; prod_d = '0; midx_d = '0;
      end
      ST_C_DIV: begin
        dn_d = mres_q; dd_d = 64'(trig_div(k_q[3:0], v2_q[31])); dr_d = '0; dcnt_d = '0;
      end
      ST_C_FIN: begin
        ma_d = s28_q; mb_d = csum; msh_d = SH_Q60; prod_d = '0; midx_d = '0;
      end
      ST_N_SM: begin
        a_d = mres_q;
        sx_d = {mean_q, 32'd0}; sr_d = '0; sb_d = SQRT_TOP;
      end
      ST_N_D: begin
        ma_d = a_q; mb_d = sr_q; msh_d = SH_Q36; prod_d = '0; midx_d = '0;
      end
      ST_N_VAL: begin
        if (vsum[65] || vsum == 66'd0) begin
          count_d = '0;
        end else if (vcnt >= 50'(SAT_LIMIT)) begin
          count_d = SAT_LIMIT;
          flag_d  = 1'b1;
        end else begin
          count_d = vcnt[30:0];
        end
      end
      ST_MUL: begin
        prod_d = prod_q + pp_sh; midx_d = midx_q + 2'd1;
      end
      ST_MSH: mres_d = 64'(prod_q >> msh_q);
      ST_DIV: begin
        dr_d   = dge ? rem_sub[63:0] : rem_sh[63:0];
        dn_d   = {dn_q[62:0], dge};
        dcnt_d = dcnt_q + 6'd1;
      end
      ST_SQB: if (sb_q > sx_q) sb_d = sb_q >> 2;
      ST_SQS: if (sb_q != 64'd0) begin
        if (sx_q >= srb) begin
          sx_d = sx_q - srb;
          sr_d = (sr_q >> 1) + sb_q;
        end else begin
          sr_d = sr_q >> 1;
        end
        sb_d = sb_q >> 2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q <= mean_d; v1_q <= v1_d; v2_q <= v2_d;
    y_q <= y_d; sum_q <= sum_d; opr_q <= opr_d; a_q <= a_d; n_q <= n_d; s28_q <= s28_d;
    frac_q <= frac_d; b_q <= b_d; k_q <= k_d; count_q <= count_d; flag_q <= flag_d;
    ma_q <= ma_d; mb_q <= mb_d; msh_q <= msh_d; prod_q <= prod_d; midx_q <= midx_d;
    mres_q <= mres_d;
    dn_q <= dn_d; dd_q <= dd_d; dr_q <= dr_d; dcnt_q <= dcnt_d;
    sx_q <= sx_d; sr_q <= sr_d; sb_q <= sb_d;
    res_count_q <= res_count_d; res_flag_q <= res_flag_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = res_valid_q;
  assign sample_count_o = res_count_q;
  assign capped_flag_o  = res_flag_q;

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(sample_count_o) && $stable(capped_flag_o)))
    else $error("stalled result changed");

  a_wait_for_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_o && out_stall_i) |=> (state_q == ST_OUT))
    else $error("result dropped while the output register was full");

  a_flag_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && capped_flag_o) |->
      (sample_count_o == SAT_LIMIT || sample_count_o == 31'(MAX_INVERSION_STEPS)))
    else $error("flag raised without cap or saturation");

endmodule

/* tb/tb_poisson_sampler_unit.sv */
// Testbench for poisson_sampler_unit: queued requests driven in bursts, with a
// bit-exact fixed-point predictor of the Poisson count checked on every result.
// Depends on poisson_pkg and poisson_sampler_unit.
`timescale 1ns / 100ps

module tb_poisson_sampler_unit import poisson_pkg::*; ();

  typedef struct packed {
    logic [31:0] mean;
    logic [31:0] draw1;
    logic [31:0] draw2;
    logic        drain;
  } request_t;

  typedef struct packed {
    logic [30:0] count;
    logic        capped;
  } sample_t;

  localparam longint CYCLE_LIMIT = 64'd80_000_000;
  localparam int     HOLD_CYCLES = 30000;
  localparam int     N_RANDOM    = 1700;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] mean_fixed_i;
  logic [31:0] uniform_first_i;
  logic [31:0] uniform_second_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [30:0] sample_count_o;
  logic        capped_flag_o;

  request_t pending_q[$];
  sample_t  samples_due_q[$];
  int       n_errors;
  int       n_taken;
  longint   n_cycles;
  bit       all_queued;

  poisson_sampler_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .mean_fixed_i, .uniform_first_i,
    .uniform_second_i, .out_valid_o, .out_stall_i, .sample_count_o, .capped_flag_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] mul_hi(input logic [63:0] a, input logic [63:0] b,
                                         input int s);
    logic [127:0] p;
    begin
      p = {64'd0, a} * {64'd0, b};
      mul_hi = 64'(p >> s);
    end
  endfunction

  function automatic logic [63:0] root64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    begin
      r = 0;
      b = SQRT_TOP;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      root64 = r;
    end
  endfunction

  function automatic logic [63:0] exp_of_neg(input logic [63:0] m);
    logic [63:0] x48;
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] acc;
    logic [63:0] term;
    logic [63:0] sh;
    begin
      x48 = m << 32;
      n = x48 / LN2_Q48;
      r = (x48 - n * LN2_Q48) << 12;
      acc = ONE_Q60;
      term = ONE_Q60;
      for (int k = 1; k <= EXP_TERMS; k++) begin
        term = mul_hi(term, r, 60) / k;
        if (k % 2) acc = acc - term;
        else acc = acc + term;
      end
      sh = n + (60 - FRACTION_BITS_DEF);
      exp_of_neg = (sh >= 64) ? 64'd0 : acc >> sh;
    end
  endfunction

  function automatic logic [63:0] sincos_q60(input logic [63:0] a, input bit odd);
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] d;
    begin
      a2 = mul_hi(a, a, 60);
      term = odd ? a : ONE_Q60;
      acc = term;
      for (int n = 1; n <= TRIG_TERMS; n++) begin
        d = odd ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
        term = mul_hi(term, a2, 60) / d;
        if (n % 2) acc = acc - term;
        else acc = acc + term;
      end
      sincos_q60 = acc[63] ? 64'd0 : acc;
    end
  endfunction

  function automatic sample_t poisson_draw(input request_t rq);
    logic [63:0] mean;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] count;
    logic        capped;
    logic [63:0] u;
    logic [63:0] p;
    logic [63:0] acc;
    logic [63:0] y;
    logic [63:0] frac;
    logic [63:0] lq;
    logic [63:0] s28;
    logic [63:0] c60;
    logic [63:0] dev;
    logic [63:0] quad;
    longint      value;
    int          b;
    sample_t     res;
    begin
      mean = {32'd0, rq.mean};
      v1 = {31'd0, rq.draw1, 1'b1};
      v2 = {31'd0, rq.draw2, 1'b1};
      count = 0;
      capped = 1'b0;
      if (mean <= (64'(SMALL_MEAN_BORDER_DEF) << 16)) begin
        u = v1 >> (33 - FRACTION_BITS_DEF);
        p = exp_of_neg(mean);
        acc = p;
        while (acc <= u) begin
          if (count >= MAX_INVERSION_STEPS_DEF) begin
            capped = 1'b1;
            break;
          end
          count = count + 1;
          p = ((p * mean) >> 16) / count;
          acc = acc + p;
        end
      end else begin
        b = 0;
        while (b < 32 && (v1 >> (b + 1)) != 0) b++;
        y = v1 << (62 - b);
        frac = 0;
        for (int i = 0; i < 32; i++) begin
          y = mul_hi(y, y, 62);
          if (y[63]) begin
            y = y >> 1;
            frac[31 - i] = 1'b1;
          end
        end
        lq = (64'(33 - b) << 32) - frac;
        s28 = root64(mul_hi(lq, LN2_Q64, 63) << 24);
        quad = v2 >> 31;
        c60 = sincos_q60(mul_hi(v2 & 64'h7FFF_FFFF, HALFPI_Q62, 33), quad[0]);
        dev = mul_hi(mul_hi(s28, c60, 60), root64(mean << 32), 36);
        value = longint'(mean) + 64'h8000;
        if (quad == 1 || quad == 2) value = value - longint'(dev);
        else value = value + longint'(dev);
        count = (value <= 0) ? 64'd0 : 64'(value) >> 16;
      end
      if (count >= 64'(SAT_LIMIT)) begin
        count = 64'(SAT_LIMIT);
        capped = 1'b1;
      end
      res.count = count[30:0];
      res.capped = capped;
      poisson_draw = res;
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, n_cycles);
    n_errors++;
  endtask

  task automatic queue_request(input logic [31:0] m, input logic [31:0] c1,
                               input logic [31:0] c2, input bit drain);
    request_t rq;
    rq.mean = m;
    rq.draw1 = c1;
    rq.draw2 = c2;
    rq.drain = drain;
    pending_q.push_back(rq);
  endtask

  function automatic logic [31:0] random_mean();
    int sel;
    begin
      sel = $urandom_range(0, 9);
      if (sel < 5) random_mean = $urandom_range(0, SMALL_MEAN_BORDER_DEF << 16);
      else if (sel < 8) random_mean = $urandom_range((SMALL_MEAN_BORDER_DEF << 16) + 1,
                                                     200 << 16);
      else random_mean = $urandom;
    end
  endfunction

  // driver: bursts of random length, random gaps, optional drain before a request
  int burst_left;
  int gap_left;
  always @(posedge clk_i or negedge rst_ni) begin
    request_t rq;
    bit       take;
    bit       done;
    if (!rst_ni) begin
      in_valid_i       <= 1'b0;
      mean_fixed_i     <= '0;
      uniform_first_i  <= '0;
      uniform_second_i <= '0;
      burst_left       <= 0;
      gap_left         <= 0;
    end else begin
      take = in_valid_i && !in_stall_o;
      done = !in_valid_i || take;
      if (take) begin
        samples_due_q.push_back(poisson_draw(pending_q.pop_front()));
        n_taken++;
      end
      if (done) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() == 0 ||
                     (pending_q[0].drain && samples_due_q.size() != 0)) begin
          in_valid_i <= 1'b0;
        end else begin
          rq = pending_q[0];
          in_valid_i       <= 1'b1;
          mean_fixed_i     <= rq.mean;
          uniform_first_i  <= rq.draw1;
          uniform_second_i <= rq.draw2;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver stall pattern, one long hold-off while requests keep coming
  int stall_mode;
  int stall_left;
  bit held_once;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= 0;
      stall_left  <= 0;
      held_once   <= 1'b0;
    end else if (!held_once && n_taken >= 300) begin
      held_once   <= 1'b1;
      stall_left  <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1) || ($urandom_range(0, 1) == 1);
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    sample_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (samples_due_q.size() == 0) begin
        report_mismatch("unexpected result", sample_count_o, -1);
      end else begin
        want = samples_due_q.pop_front();
        if (sample_count_o !== want.count)
          report_mismatch("sample_count", sample_count_o, want.count);
        if (capped_flag_o !== want.capped)
          report_mismatch("capped_flag", capped_flag_o, want.capped);
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("tb_poisson_sampler_unit: done, errors");
      $finish;
    end
  end

  initial begin
    n_errors = 0;
    n_taken = 0;
    n_cycles = 0;
    all_queued = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_request(32'd0, 32'd0, 32'd0, 1'b0);
    queue_request(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_request(32'h0000_0001, 32'h8000_0000, 32'h0, 1'b0);
    queue_request(32'h0001_0000, 32'h4000_0000, 32'h1234_5678, 1'b0);
    queue_request(32'h0010_0000, 32'hFFFF_FFFF, 32'h0, 1'b0);
    queue_request(32'h0010_0000, 32'hFFFF_FFF0, 32'h0, 1'b0);
    queue_request(32'h0010_0000, 32'd0, 32'h0, 1'b0);
    queue_request(32'h0010_0001, 32'h8000_0000, 32'h0, 1'b0);
    queue_request(32'h0010_0001, 32'd0, 32'h8000_0000, 1'b0);
    queue_request(32'h0010_0001, 32'd0, 32'h7FFF_FFFF, 1'b0);
    queue_request(32'h0010_0001, 32'd0, 32'h0, 1'b0);
    queue_request(32'h0010_0001, 32'd0, 32'hC000_0000, 1'b0);
    queue_request(32'h0010_0001, 32'hFFFF_FFFF, 32'h4000_0000, 1'b0);
    queue_request(32'h0010_0001, 32'd1, 32'hBFFF_FFFF, 1'b0);
    queue_request(32'hFFFF_FFFF, 32'd0, 32'h0, 1'b0);
    queue_request(32'hFFFF_FFFF, 32'd0, 32'h8000_0000, 1'b0);
    queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    queue_request(32'h0064_8000, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    queue_request(32'h0000_8000, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    for (int i = 0; i < N_RANDOM; i++)
      queue_request(random_mean(), $urandom, $urandom, i == N_RANDOM / 2);
    all_queued = 1'b1;

    wait (pending_q.size() == 0 && samples_due_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (n_errors == 0 && samples_due_q.size() == 0) begin
      $display("tb_poisson_sampler_unit: done, clean");
    end else begin
      $display("tb_poisson_sampler_unit: done, errors");
    end
    $finish;
  end

endmodule
